// File: sv/priority_interrupt_device_hub_top_defines.svh
// Assertion macros used by the interrupt hub top level
`ifndef PRIORITY_INTERRUPT_DEVICE_HUB_TOP_DEFINES_SVH
`define PRIORITY_INTERRUPT_DEVICE_HUB_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i, quiet during reset
`define PIDH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interrupt hub check failed");

// Next-cycle implication, checked on clk_i, quiet during reset
`define PIDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interrupt hub check failed");

`endif

// File: sv/pidh_pkg.sv
// Types and constants of the priority interrupt device hub
`timescale 1ns / 1ps

package pidh_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned PeriodW = 16;

  // Bus and time events
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_KEY       = 3'd1,
    FUNC_NMI_REQ   = 3'd2,
    FUNC_IN_READ   = 3'd3,
    FUNC_OUT_READ  = 3'd4,
    FUNC_OUT_WRITE = 3'd5,
    FUNC_ACK       = 3'd6,
    FUNC_DEV_RESET = 3'd7
  } func_e;

  // Device interrupt levels
  localparam logic [LevelW-1:0] LvlNone = 3'd0;
  localparam logic [LevelW-1:0] LvlOut  = 3'd1;
  localparam logic [LevelW-1:0] LvlKey  = 3'd2;
  localparam logic [LevelW-1:0] LvlNmi  = 3'd7;

  // Acknowledge answers
  localparam logic AckAuto  = 1'b0;
  localparam logic AckSpur  = 1'b1;

  localparam logic [PeriodW-1:0] CountMax     = 16'hffff;
  localparam logic [PeriodW-1:0] PeriodReset  = 16'd1;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [ByteW-1:0]  data;
    logic [LevelW-1:0] level;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]  read_data;
    logic [LevelW-1:0] irq_level;
    logic              ack_code;
    logic              char_valid;
    logic [ByteW-1:0]  char_out;
  } result_t;

endpackage

// File: sv/pidh_in_if.sv
// Input channel of the interrupt hub: one bus or time event per beat
`timescale 1ns / 1ps

interface pidh_in_if;
  logic                         valid;
  logic                         ready;
  logic [pidh_pkg::FuncW-1:0]   func;
  logic [pidh_pkg::ByteW-1:0]   data;
  logic [pidh_pkg::LevelW-1:0]  level;

  modport source (output valid, output func, output data, output level, input ready);
  modport sink   (input valid, input func, input data, input level, output ready);
endinterface

// File: sv/pidh_out_if.sv
// Result channel of the interrupt hub: one result per beat
`timescale 1ns / 1ps

interface pidh_out_if;
  logic                         valid;
  logic                         ready;
  logic [pidh_pkg::ByteW-1:0]   read_data;
  logic [pidh_pkg::LevelW-1:0]  irq_level;
  logic                         ack_code;
  logic                         char_valid;
  logic [pidh_pkg::ByteW-1:0]   char_out;

  modport source (output valid, output read_data, output irq_level, output ack_code,
                  output char_valid, output char_out, input ready);
  modport sink   (input valid, input read_data, input irq_level, input ack_code,
                  input char_valid, input char_out, output ready);
endinterface

// File: sv/pidh_core.sv
// Device state, pending levels and the per-event update logic
`timescale 1ns / 1ps

module pidh_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  pidh_pkg::item_t                item_i,
  input  logic                           cfg_we_i,
  input  logic [pidh_pkg::PeriodW-1:0]   cfg_wdata_i,
  output pidh_pkg::result_t              result_o
);

  logic                          nmi_lvl_q, nmi_lvl_d;
  logic                          key_lvl_q, key_lvl_d;
  logic                          out_lvl_q, out_lvl_d;
  logic                          nmi_pend_q, nmi_pend_d;
  logic                          key_held_q, key_held_d;
  logic [pidh_pkg::ByteW-1:0]    key_byte_q, key_byte_d;
  logic                          out_rdy_q, out_rdy_d;
  logic [pidh_pkg::PeriodW-1:0]  ticks_q, ticks_d;
  logic [pidh_pkg::PeriodW-1:0]  ticks_inc;
  logic [pidh_pkg::PeriodW-1:0]  period_q;
  pidh_pkg::func_e               func;

  assign func      = pidh_pkg::func_e'(item_i.func);
  assign ticks_inc = (ticks_q != pidh_pkg::CountMax) ? ticks_q + 16'd1 : ticks_q;

  // Apply one event to the device state and form its result
  always_comb begin
    nmi_lvl_d  = nmi_lvl_q;
    key_lvl_d  = key_lvl_q;
    out_lvl_d  = out_lvl_q;
    nmi_pend_d = nmi_pend_q;
    key_held_d = key_held_q;
    key_byte_d = key_byte_q;
    out_rdy_d  = out_rdy_q;
    ticks_d    = ticks_q;
    result_o   = '0;
    result_o.ack_code = pidh_pkg::AckAuto;

    unique case (func)
      pidh_pkg::FUNC_TICK: begin
        if (nmi_pend_q) begin
          nmi_pend_d = 1'b0;
          nmi_lvl_d  = 1'b1;
        end
        if (key_held_q) begin
          key_lvl_d = 1'b1;
        end
        ticks_d = ticks_inc;
        if (!out_rdy_q && (ticks_inc >= period_q)) begin
          out_rdy_d = 1'b1;
          out_lvl_d = 1'b1;
        end
      end
      pidh_pkg::FUNC_KEY: begin
        key_byte_d = item_i.data;
        key_held_d = 1'b1;
      end
      pidh_pkg::FUNC_NMI_REQ: begin
        nmi_pend_d = 1'b1;
      end
      pidh_pkg::FUNC_IN_READ: begin
        result_o.read_data = key_held_q ? key_byte_q : '0;
        key_lvl_d  = 1'b0;
        key_held_d = 1'b0;
        key_byte_d = '0;
      end
      pidh_pkg::FUNC_OUT_READ: begin
        out_lvl_d = 1'b0;
      end
      pidh_pkg::FUNC_OUT_WRITE: begin
        // Drop writes while the port is busy
        if (out_rdy_q) begin
          result_o.char_valid = 1'b1;
          result_o.char_out   = item_i.data;
          ticks_d   = '0;
          out_rdy_d = 1'b0;
          out_lvl_d = 1'b0;
        end
      end
      pidh_pkg::FUNC_ACK: begin
        if (item_i.level == pidh_pkg::LvlNmi) begin
          nmi_lvl_d = 1'b0;
        end else if (item_i.level != pidh_pkg::LvlKey &&
                     item_i.level != pidh_pkg::LvlOut) begin
          result_o.ack_code = pidh_pkg::AckSpur;
        end
      end
      pidh_pkg::FUNC_DEV_RESET: begin
        // A level 7 already pending survives a device reset
        nmi_pend_d = 1'b0;
        key_held_d = 1'b0;
        key_byte_d = '0;
        key_lvl_d  = 1'b0;
        ticks_d    = '0;
        out_rdy_d  = 1'b0;
        out_lvl_d  = 1'b0;
      end
      default: begin
      end
    endcase

    // Priority encode the pending levels after the event
    if (nmi_lvl_d) begin
      result_o.irq_level = pidh_pkg::LvlNmi;
    end else if (key_lvl_d) begin
      result_o.irq_level = pidh_pkg::LvlKey;
    end else if (out_lvl_d) begin
      result_o.irq_level = pidh_pkg::LvlOut;
    end else begin
      result_o.irq_level = pidh_pkg::LvlNone;
    end
  end

  // Commit the device state when an event leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmi_lvl_q  <= 1'b0;
      key_lvl_q  <= 1'b0;
      out_lvl_q  <= 1'b0;
      nmi_pend_q <= 1'b0;
      key_held_q <= 1'b0;
      key_byte_q <= '0;
      out_rdy_q  <= 1'b0;
      ticks_q    <= '0;
    end else if (fire_i) begin
      nmi_lvl_q  <= nmi_lvl_d;
      key_lvl_q  <= key_lvl_d;
      out_lvl_q  <= out_lvl_d;
      nmi_pend_q <= nmi_pend_d;
      key_held_q <= key_held_d;
      key_byte_q <= key_byte_d;
      out_rdy_q  <= out_rdy_d;
      ticks_q    <= ticks_d;
    end
  end

  // Hold the output period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= pidh_pkg::PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

endmodule

// File: sv/priority_interrupt_device_hub_top.sv
// Top level of the priority interrupt device hub
//
//   channel  dir  handshake    beat contents
//   in_i     in   valid/ready  func, data, level
//   out_o    out  valid/ready  read_data, irq_level, ack_code, char_valid, char_out
//   cfg      in   cfg_we_i     cfg_wdata_i = output period
//
// An event passes from input beat to result beat through the input register,
// then the device update and priority encoder into the result register.
// One event is accepted every cycle while the result side takes beats.
// A stalled result holds the result register; the input register still
// takes one more beat, then in_i.ready drops. Reset is asynchronous and
// clears all device state; there is no clearing pass.
`timescale 1ns / 1ps
`include "priority_interrupt_device_hub_top_defines.svh"

module priority_interrupt_device_hub_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pidh_in_if.sink                       in_i,
  pidh_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [pidh_pkg::PeriodW-1:0]  cfg_wdata_i
);

  logic               s1_valid_q;
  pidh_pkg::item_t    s1_item_q;
  logic               out_valid_q;
  pidh_pkg::result_t  res_q;
  pidh_pkg::result_t  core_res;
  logic               advance;
  logic               fire;
  logic               in_beat;
  logic               irq_legal;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_beat    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_beat) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_item_q.func  <= in_i.func;
      s1_item_q.data  <= in_i.data;
      s1_item_q.level <= in_i.level;
    end
  end

  pidh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_item_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = res_q.read_data;
  assign out_o.irq_level  = res_q.irq_level;
  assign out_o.ack_code   = res_q.ack_code;
  assign out_o.char_valid = res_q.char_valid;
  assign out_o.char_out   = res_q.char_out;

  // Only device levels or none ever reach the CPU
  assign irq_legal = (res_q.irq_level == pidh_pkg::LvlNone) ||
                     (res_q.irq_level == pidh_pkg::LvlOut)  ||
                     (res_q.irq_level == pidh_pkg::LvlKey)  ||
                     (res_q.irq_level == pidh_pkg::LvlNmi);

  `PIDH_ASSERT_IMPL(a_full_stall_blocks_input, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready)
  `PIDH_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_q)
  `PIDH_ASSERT_IMPL(a_irq_level_legal, out_valid_q, irq_legal)
  `PIDH_ASSERT_IMPL(a_no_char_no_data, out_valid_q && !res_q.char_valid, res_q.char_out == '0)

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the priority interrupt device hub
`timescale 1ns / 1ps

// Scoreboard: tracks the hub's device state and queues the result of each input beat
class irq_hub_scoreboard;
  logic [15:0] period;
  logic [7:0]  pend;
  logic [2:0]  top;
  bit          nmi_req;
  bit          key_full;
  logic [7:0]  key_val;
  bit          port_ready;
  logic [15:0] tick_count;
  pidh_pkg::result_t want_q[$];
  int unsigned errors;

  function new();
    period     = pidh_pkg::PeriodReset;
    pend       = '0;
    top        = pidh_pkg::LvlNone;
    nmi_req    = 1'b0;
    key_full   = 1'b0;
    key_val    = '0;
    port_ready = 1'b0;
    tick_count = '0;
    errors     = 0;
  endfunction

  function int unsigned outstanding();
    return want_q.size();
  endfunction

  // Set a pending bit; the CPU level only moves up on a newly set bit
  function void raise(logic [2:0] lv);
    logic [7:0] prev;
    prev     = pend;
    pend[lv] = 1'b1;
    if (prev != pend && lv > top) top = lv;
  endfunction

  // Clear a pending bit and re-encode the highest of levels 7..1
  function void drop(logic [2:0] lv);
    pend[lv] = 1'b0;
    top      = pidh_pkg::LvlNone;
    for (int l = 1; l < 8; l++) begin
      if (pend[l]) top = 3'(l);
    end
  endfunction

  // Advance the device state by one accepted input beat and queue its result
  function void note_item(pidh_pkg::item_t it);
    pidh_pkg::result_t want;
    want = '0;
    case (pidh_pkg::func_e'(it.func))
      pidh_pkg::FUNC_TICK: begin
        if (nmi_req) begin
          nmi_req = 1'b0;
          raise(pidh_pkg::LvlNmi);
        end
        if (key_full) raise(pidh_pkg::LvlKey);
        if (tick_count != pidh_pkg::CountMax) tick_count++;
        if (!port_ready && tick_count >= period) begin
          port_ready = 1'b1;
          raise(pidh_pkg::LvlOut);
        end
      end
      pidh_pkg::FUNC_KEY: begin
        key_val  = it.data;
        key_full = 1'b1;
      end
      pidh_pkg::FUNC_NMI_REQ: nmi_req = 1'b1;
      pidh_pkg::FUNC_IN_READ: begin
        want.read_data = key_full ? key_val : 8'h00;
        drop(pidh_pkg::LvlKey);
        key_full = 1'b0;
        key_val  = '0;
      end
      pidh_pkg::FUNC_OUT_READ: drop(pidh_pkg::LvlOut);
      pidh_pkg::FUNC_OUT_WRITE: begin
        if (port_ready) begin
          want.char_valid = 1'b1;
          want.char_out   = it.data;
          tick_count      = '0;
          port_ready      = 1'b0;
          drop(pidh_pkg::LvlOut);
        end
      end
      pidh_pkg::FUNC_ACK: begin
        if (it.level == pidh_pkg::LvlNmi) begin
          drop(pidh_pkg::LvlNmi);
          want.ack_code = pidh_pkg::AckAuto;
        end else if (it.level == pidh_pkg::LvlKey || it.level == pidh_pkg::LvlOut) begin
          want.ack_code = pidh_pkg::AckAuto;
        end else begin
          want.ack_code = pidh_pkg::AckSpur;
        end
      end
      default: begin
        nmi_req    = 1'b0;
        key_full   = 1'b0;
        key_val    = '0;
        drop(pidh_pkg::LvlKey);
        tick_count = '0;
        port_ready = 1'b0;
        drop(pidh_pkg::LvlOut);
      end
    endcase
    want.irq_level = top;
    want_q.push_back(want);
  endfunction

  // Compare one result beat against the oldest queued expectation
  function void check_result(pidh_pkg::result_t got);
    pidh_pkg::result_t want;
    if (want_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result beat: rd=%02h irq=%0d ack=%0b cv=%0b ch=%02h",
                 got.read_data, got.irq_level, got.ack_code, got.char_valid, got.char_out);
      return;
    end
    want = want_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("result mismatch: exp rd=%02h irq=%0d ack=%0b cv=%0b ch=%02h",
                 want.read_data, want.irq_level, want.ack_code, want.char_valid,
                 want.char_out);
        $display("                 got rd=%02h irq=%0d ack=%0b cv=%0b ch=%02h",
                 got.read_data, got.irq_level, got.ack_code, got.char_valid,
                 got.char_out);
      end
    end
  endfunction
endclass

module tb_top;
  import pidh_pkg::*;

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned HoldCycles = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  bit          steady;
  bit          hold_req;
  int unsigned cycles;

  irq_hub_scoreboard sb = new();

  pidh_in_if  in_if();
  pidh_out_if out_if();

  priority_interrupt_device_hub_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung run
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: check each beat, stall at random or hold off on request
  initial begin
    int unsigned hold_left;
    result_t     got;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.read_data  = out_if.read_data;
        got.irq_level  = out_if.irq_level;
        got.ack_code   = out_if.ack_code;
        got.char_valid = out_if.char_valid;
        got.char_out   = out_if.char_out;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  function automatic item_t mk(func_e f, logic [7:0] d, logic [2:0] lv);
    item_t it;
    it.func  = f;
    it.data  = d;
    it.level = lv;
    return it;
  endfunction

  // Random event mix, biased toward ticks and output writes, acks mostly on device levels
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    it.data  = 8'($urandom_range(0, 255));
    it.level = 3'($urandom_range(0, 7));
    if (pick < 34)      it.func = FUNC_TICK;
    else if (pick < 46) it.func = FUNC_KEY;
    else if (pick < 54) it.func = FUNC_NMI_REQ;
    else if (pick < 63) it.func = FUNC_IN_READ;
    else if (pick < 69) it.func = FUNC_OUT_READ;
    else if (pick < 84) it.func = FUNC_OUT_WRITE;
    else if (pick < 95) it.func = FUNC_ACK;
    else                it.func = FUNC_DEV_RESET;
    if (it.func == FUNC_ACK) begin
      case ($urandom_range(0, 3))
        0: it.level = LvlNmi;
        1: it.level = LvlKey;
        2: it.level = LvlOut;
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offer one beat and hold it until the hub takes it
  task automatic send_item(input item_t it);
    in_if.valid <= 1'b1;
    in_if.func  <= it.func;
    in_if.data  <= it.data;
    in_if.level <= it.level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(it);
  endtask

  // Random one-cycle gap on the input side
  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < 11) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result is back, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [15:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.period = p;
  endtask

  // One configuration phase of random events
  task automatic run_phase(input logic [15:0] p, input int unsigned n_items,
                           input bit calm, input bit squeeze);
    drain();
    write_period(p);
    steady = calm;
    if (squeeze) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      send_item(random_item());
      if (squeeze && i == n_items / 2) drain();
      else maybe_idle();
    end
  endtask

  initial begin
    item_t directed[$];

    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.func  <= FUNC_TICK;
    in_if.data  <= '0;
    in_if.level <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through every event at the reset period
    directed = '{
      mk(FUNC_TICK, 8'h00, 3'd0),          // port ready, level 1
      mk(FUNC_OUT_READ, 8'h00, 3'd0),      // clear level 1
      mk(FUNC_OUT_WRITE, 8'hff, 3'd0),     // emit
      mk(FUNC_OUT_WRITE, 8'h00, 3'd0),     // port busy, ignored
      mk(FUNC_KEY, 8'hff, 3'd0),
      mk(FUNC_TICK, 8'h00, 3'd0),          // key and port raise together
      mk(FUNC_NMI_REQ, 8'h00, 3'd0),
      mk(FUNC_TICK, 8'h00, 3'd0),          // nmi raises level 7
      mk(FUNC_ACK, 8'h00, LvlNmi),
      mk(FUNC_ACK, 8'h00, LvlKey),
      mk(FUNC_ACK, 8'h00, LvlOut),
      mk(FUNC_ACK, 8'h00, 3'd0),           // spurious
      mk(FUNC_ACK, 8'h00, 3'd3),
      mk(FUNC_ACK, 8'h00, 3'd6),
      mk(FUNC_IN_READ, 8'h00, 3'd0),       // returns held key
      mk(FUNC_IN_READ, 8'h00, 3'd0),       // empty latch reads zero
      mk(FUNC_KEY, 8'h00, 3'd0),
      mk(FUNC_KEY, 8'ha5, 3'd0),           // overwrite held key
      mk(FUNC_TICK, 8'h00, 3'd0),
      mk(FUNC_OUT_WRITE, 8'h5a, 3'd0),
      mk(FUNC_NMI_REQ, 8'h00, 3'd0),
      mk(FUNC_DEV_RESET, 8'h00, 3'd0),     // drops nmi request, key and port
      mk(FUNC_TICK, 8'h00, 3'd0),
      mk(FUNC_ACK, 8'h00, LvlNmi)          // level 7 not pending
    };
    foreach (directed[i]) begin
      send_item(directed[i]);
      maybe_idle();
    end

    run_phase(16'd0, 200, 1'b0, 1'b0);     // zero period acts like one
    run_phase(CountMax, 150, 1'b0, 1'b0);
    run_phase(16'd2, 250, 1'b1, 1'b0);     // no idling on either side
    run_phase(16'd3, 250, 1'b0, 1'b1);     // long result hold-off, then sender pause
    run_phase(16'($urandom_range(4, 40)), 300, 1'b0, 1'b0);
    run_phase(PeriodReset, 300, 1'b0, 1'b0);
    run_phase(16'($urandom_range(1, 65535)), 100, 1'b0, 1'b0);
    run_phase(PeriodReset, 300, 1'b0, 1'b0);
    drain();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/pidh_pkg.sv
sv/pidh_in_if.sv
sv/pidh_out_if.sv
sv/pidh_core.sv
sv/priority_interrupt_device_hub_top.sv
sim/tb_top.sv
